[rtl/multi_channel_led_blinker_top_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros for the led blink timer bank
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_LED_BLINKER_TOP_MACROS_SVH
`define MULTI_CHANNEL_LED_BLINKER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define MCLB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mclb assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define MCLB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mclb assertion failed");

`endif

[rtl/mclb_pkg.sv]
// ----------------------------------------------------------------------------
// mclb_pkg
// shared constants and types of the led blink timer bank
// ----------------------------------------------------------------------------
package mclb_pkg;

  localparam int CHANNELS  = 5;
  localparam int TIME_BITS = 16;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 3;
  localparam int FIELD_W = 16;
  localparam int COUNT_W = 16;
  localparam int PAT_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic apply;    // update the channels and load the result register
  } ctrl_cmd_t;

endpackage

[rtl/multi_channel_led_blinker_top.sv]
// ----------------------------------------------------------------------------
// multi_channel_led_blinker_top
// bank of independent led blink channels driven by tick, start and cancel
// ----------------------------------------------------------------------------
//
// channel | handshake                | payload
// --------+--------------------------+-------------------------------------------
// in      | in_valid_i / in_ready_o   | opcode, led_index, on/off time, repeat_count
// out     | out_valid_o / out_ready_i | led_pattern, status
//
// an item is captured at its transfer edge and applied to the channels once the
// result register is free, at the edge that also loads its result for the output
// back to back items go at one per cycle while out_ready_i stays high
// reset clears all channels to inactive and empties the result register
// a stalled result holds a waiting item in the command register; in_ready_o then drops
// ----------------------------------------------------------------------------
module multi_channel_led_blinker_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mclb_pkg::OP_W-1:0]           opcode_i,
  input  logic [mclb_pkg::IDX_W-1:0]          led_index_i,
  input  logic [mclb_pkg::FIELD_W-1:0]        on_time_i,
  input  logic [mclb_pkg::FIELD_W-1:0]        off_time_i,
  input  logic signed [mclb_pkg::COUNT_W-1:0] repeat_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mclb_pkg::PAT_W-1:0]          led_pattern_o,
  output logic                                status_o
);
  import mclb_pkg::*;

  // capture / apply strobes between controller and datapath
  ctrl_cmd_t cmd;

  // controller: decides when an item transfers and when it is applied
  mclb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath: channel timers, repeat counters and the result register
  mclb_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (opcode_i),
    .led_index_i    (led_index_i),
    .on_time_i      (on_time_i),
    .off_time_i     (off_time_i),
    .repeat_count_i (repeat_count_i),
    .led_pattern_o  (led_pattern_o),
    .status_o       (status_o)
  );

endmodule

[rtl/mclb_datapath.sv]
// ----------------------------------------------------------------------------
// mclb_datapath
// command register, per-channel blink state and result register
// ----------------------------------------------------------------------------
module mclb_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mclb_pkg::ctrl_cmd_t               cmd_i,
  input  logic [mclb_pkg::OP_W-1:0]         opcode_i,
  input  logic [mclb_pkg::IDX_W-1:0]        led_index_i,
  input  logic [mclb_pkg::FIELD_W-1:0]      on_time_i,
  input  logic [mclb_pkg::FIELD_W-1:0]      off_time_i,
  input  logic signed [mclb_pkg::COUNT_W-1:0] repeat_count_i,
  output logic [mclb_pkg::PAT_W-1:0]        led_pattern_o,
  output logic                              status_o
);
  import mclb_pkg::*;

  typedef logic [TIME_BITS-1:0] time_t;

  function automatic time_t fix_time(input logic [FIELD_W-1:0] raw);
    time_t t;
    t = '0;
    for (int i = 0; i < TIME_BITS; i++) begin
      if (i < FIELD_W) begin
        t[i] = raw[i];
      end
    end
    return (t == '0) ? time_t'(1) : t;
  endfunction

  // latched item
  opcode_e                    op_q;
  logic [IDX_W-1:0]           idx_q;
  logic [FIELD_W-1:0]         on_q;
  logic [FIELD_W-1:0]         off_q;
  logic signed [COUNT_W-1:0]  rc_q;

  // channel state
  logic [CHANNELS-1:0]        act_q, act_d;
  logic [CHANNELS-1:0]        pon_q, pon_d;
  time_t                      tmr_q [CHANNELS];
  time_t                      tmr_d [CHANNELS];
  logic signed [COUNT_W-1:0]  rep_q [CHANNELS];
  logic signed [COUNT_W-1:0]  rep_d [CHANNELS];
  time_t                      son_q [CHANNELS];
  time_t                      son_d [CHANNELS];
  time_t                      soff_q [CHANNELS];
  time_t                      soff_d [CHANNELS];

  logic [PAT_W-1:0]           pat_d, pat_q;
  logic                       sts_d, sts_q;
  logic                       idx_ok;
  logic                       both_zero;
  time_t                      on_fix;
  time_t                      off_fix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= OP_TICK;
      idx_q <= '0;
      on_q  <= '0;
      off_q <= '0;
      rc_q  <= '0;
    end else if (cmd_i.capture) begin
      op_q  <= opcode_e'(opcode_i);
      idx_q <= led_index_i;
      on_q  <= on_time_i;
      off_q <= off_time_i;
      rc_q  <= repeat_count_i;
    end
  end

  assign idx_ok    = ({1'b0, idx_q} < (IDX_W+1)'(CHANNELS));
  assign both_zero = (on_q == '0) && (off_q == '0);
  assign on_fix    = fix_time(on_q);
  assign off_fix   = fix_time(off_q);

  always_comb begin
    act_d = act_q;
    pon_d = pon_q;
    tmr_d = tmr_q;
    rep_d = rep_q;
    son_d = son_q;
    soff_d = soff_q;
    sts_d = 1'b0;
    unique case (op_q)
      OP_TICK: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (act_q[c]) begin
            if (tmr_q[c] > time_t'(1)) begin
              tmr_d[c] = tmr_q[c] - time_t'(1);
            end else if (pon_q[c]) begin
              pon_d[c] = 1'b0;
              tmr_d[c] = soff_q[c];
            end else if (!rep_q[c][COUNT_W-1] && rep_q[c] == COUNT_W'(1)) begin
              // last repeat done
              rep_d[c] = '0;
              act_d[c] = 1'b0;
              tmr_d[c] = '0;
            end else begin
              if (!rep_q[c][COUNT_W-1] && rep_q[c] != '0) begin
                rep_d[c] = rep_q[c] - COUNT_W'(1);
              end
              pon_d[c] = 1'b1;
              tmr_d[c] = son_q[c];
            end
          end
        end
      end
      OP_START: begin
        if (!idx_ok || both_zero) begin
          sts_d = 1'b1;
        end else begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (idx_q == IDX_W'(c)) begin
              son_d[c]  = on_fix;
              soff_d[c] = off_fix;
              rep_d[c]  = rc_q;
              act_d[c]  = 1'b1;
              pon_d[c]  = 1'b1;
              tmr_d[c]  = on_fix;
            end
          end
        end
      end
      OP_CANCEL: begin
        if (!idx_ok) begin
          sts_d = 1'b1;
        end else begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (idx_q == IDX_W'(c)) begin
              act_d[c] = 1'b0;
              pon_d[c] = 1'b0;
              tmr_d[c] = '0;
            end
          end
        end
      end
      default: begin
        sts_d = 1'b1;
      end
    endcase
  end

  always_comb begin
    pat_d = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < PAT_W) begin
        pat_d[c] = act_d[c] & pon_d[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      pon_q <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        tmr_q[c] <= '0;
        rep_q[c] <= '0;
      end
    end else if (cmd_i.apply) begin
      act_q <= act_d;
      pon_q <= pon_d;
      tmr_q <= tmr_d;
      rep_q <= rep_d;
    end
  end

  // stored times are written by a start before any read
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      son_q  <= son_d;
      soff_q <= soff_d;
      pat_q  <= pat_d;
      sts_q  <= sts_d;
    end
  end

  assign led_pattern_o = pat_q;
  assign status_o      = sts_q;

endmodule

[rtl/mclb_ctrl.sv]
// ----------------------------------------------------------------------------
// mclb_ctrl
// handshake controller: command register occupancy and result valid
// ----------------------------------------------------------------------------
module mclb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mclb_pkg::ctrl_cmd_t cmd_o
);
  import mclb_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic in_xfer;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = in_xfer;
    cmd_o.apply   = 1'b0;
    out_valid_d   = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.apply = 1'b1;
          out_valid_d = 1'b1;
          state_d     = in_xfer ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/mclb_checker.sv]
// ----------------------------------------------------------------------------
// mclb_checker
// port-level checks of the led blink timer bank, bound to the top level
// ----------------------------------------------------------------------------
`include "multi_channel_led_blinker_top_macros.svh"

module mclb_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [mclb_pkg::OP_W-1:0]           opcode_i,
  input logic [mclb_pkg::IDX_W-1:0]          led_index_i,
  input logic [mclb_pkg::FIELD_W-1:0]        on_time_i,
  input logic [mclb_pkg::FIELD_W-1:0]        off_time_i,
  input logic signed [mclb_pkg::COUNT_W-1:0] repeat_count_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [mclb_pkg::PAT_W-1:0]          led_pattern_o,
  input logic                                status_o
);

  // a stalled result stays put
  `MCLB_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(led_pattern_o) && $stable(status_o))

  // a waiting input transfer keeps its payload
  `MCLB_ASSERT_NXT(a_in_hold, in_valid_i && !in_ready_o,
                   in_valid_i && $stable(opcode_i) && $stable(led_index_i) &&
                   $stable(on_time_i) && $stable(off_time_i) && $stable(repeat_count_i))

  // input only backs up behind a waiting result
  `MCLB_ASSERT_IMP(a_ready_low_needs_result, !in_ready_o, out_valid_o)

  // every transfer is followed by a valid result on the port
  `MCLB_ASSERT_NXT(a_result_follows, in_valid_i && in_ready_o, ##1 out_valid_o)

endmodule

bind multi_channel_led_blinker_top mclb_checker u_mclb_checker (.*);
